FILE: hdl/fsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_pkg
// Shared types and constants for the FASTA stream validator.
// ----------------------------------------------------------------------------
package fsv_pkg;

    localparam logic [2:0] KIND_NAME      = 3'd0;
    localparam logic [2:0] KIND_BASE      = 3'd1;
    localparam logic [2:0] KIND_CLOSED    = 3'd2;
    localparam logic [2:0] KIND_END_REC   = 3'd3;
    localparam logic [2:0] KIND_END_EMPTY = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_EOS  = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_GT    = 8'd62;
    localparam logic [7:0] CHAR_A     = 8'd65;
    localparam logic [7:0] CHAR_C     = 8'd67;
    localparam logic [7:0] CHAR_G     = 8'd71;
    localparam logic [7:0] CHAR_N     = 8'd78;
    localparam logic [7:0] CHAR_T     = 8'd84;

    typedef enum logic [3:0] {
        PH_START     = 4'b0001,
        PH_HDR_EMPTY = 4'b0010,
        PH_HDR_NAME  = 4'b0100,
        PH_BASES     = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t line_phase;
        logic   have_header;
        logic   have_bases;
        logic   halted;
    } parse_state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        line_phase:  PH_START,
        have_header: 1'b0,
        have_bases:  1'b0,
        halted:      1'b0
    };

endpackage

FILE: hdl/fsv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_step
// Per-byte parse rule: next parser state and the optional result.
// ----------------------------------------------------------------------------
module fsv_step
(
    input  fsv_pkg::parse_state_t state,
    input  logic                  mode,
    input  logic [7:0]            symbol,
    output fsv_pkg::parse_state_t state_next,
    output logic                  emit,
    output fsv_pkg::result_t      result
);

    logic [7:0] upper;
    logic [7:0] base_up;
    logic       base_ok;

    always_comb
    begin
        upper   = (symbol >= 8'd97 && symbol <= 8'd122) ? (symbol - 8'd32) : symbol;
        base_ok = (upper == fsv_pkg::CHAR_A) || (upper == fsv_pkg::CHAR_C) ||
                  (upper == fsv_pkg::CHAR_G) || (upper == fsv_pkg::CHAR_N) ||
                  (upper == fsv_pkg::CHAR_T);
        base_up = base_ok ? upper : 8'd0;
    end

    always_comb
    begin
        state_next  = state;
        emit        = 1'b0;
        result.kind = fsv_pkg::KIND_ERROR;
        result.data = 8'd0;

        if (mode == fsv_pkg::MODE_EOS)
        begin
            state_next = fsv_pkg::STATE_RESET;
            emit       = !state.halted;
            if (state.line_phase == fsv_pkg::PH_HDR_EMPTY)
                result.kind = fsv_pkg::KIND_ERROR;
            else if (state.have_header && state.have_bases)
                result.kind = fsv_pkg::KIND_END_REC;
            else if (state.have_header)
                result.kind = fsv_pkg::KIND_ERROR;
            else
                result.kind = fsv_pkg::KIND_END_EMPTY;
        end
        else if (!state.halted)
        begin
            unique case (state.line_phase)
                fsv_pkg::PH_START:
                begin
                    if (symbol == fsv_pkg::CHAR_LF || symbol == fsv_pkg::CHAR_SPACE)
                    begin
                        state_next.halted = 1'b1;
                        emit              = 1'b1;
                    end
                    else if (symbol == fsv_pkg::CHAR_GT)
                    begin
                        state_next.line_phase = fsv_pkg::PH_HDR_EMPTY;
                        if (state.have_header && state.have_bases)
                        begin
                            state_next.have_header = 1'b0;
                            state_next.have_bases  = 1'b0;
                            emit                   = 1'b1;
                            result.kind            = fsv_pkg::KIND_CLOSED;
                        end
                        else if (state.have_header)
                        begin
                            state_next.halted = 1'b1;
                            emit              = 1'b1;
                        end
                    end
                    else if (!state.have_header || !base_ok)
                    begin
                        state_next.halted = 1'b1;
                        emit              = 1'b1;
                    end
                    else
                    begin
                        state_next.have_bases = 1'b1;
                        state_next.line_phase = fsv_pkg::PH_BASES;
                        emit                  = 1'b1;
                        result.kind           = fsv_pkg::KIND_BASE;
                        result.data           = base_up;
                    end
                end
                fsv_pkg::PH_HDR_EMPTY:
                begin
                    emit = 1'b1;
                    if (symbol == fsv_pkg::CHAR_LF)
                        state_next.halted = 1'b1;
                    else
                    begin
                        state_next.have_header = 1'b1;
                        state_next.line_phase  = fsv_pkg::PH_HDR_NAME;
                        result.kind            = fsv_pkg::KIND_NAME;
                        result.data            = symbol;
                    end
                end
                fsv_pkg::PH_HDR_NAME:
                begin
                    if (symbol == fsv_pkg::CHAR_LF)
                        state_next.line_phase = fsv_pkg::PH_START;
                    else
                    begin
                        emit        = 1'b1;
                        result.kind = fsv_pkg::KIND_NAME;
                        result.data = symbol;
                    end
                end
                fsv_pkg::PH_BASES:
                begin
                    if (symbol == fsv_pkg::CHAR_LF)
                        state_next.line_phase = fsv_pkg::PH_START;
                    else if (!base_ok)
                    begin
                        state_next.halted = 1'b1;
                        emit              = 1'b1;
                    end
                    else
                    begin
                        state_next.have_bases = 1'b1;
                        emit                  = 1'b1;
                        result.kind           = fsv_pkg::KIND_BASE;
                        result.data           = base_up;
                    end
                end
                default:
                begin
                    state_next = fsv_pkg::STATE_RESET;
                end
            endcase
        end
    end

endmodule

FILE: hdl/fsv_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_out_reg
// Result register on the master side; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module fsv_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fsv_pkg::result_t load_data,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output fsv_pkg::result_t m_result
);

    logic             valid_reg;
    logic             valid_next;
    fsv_pkg::result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

endmodule

FILE: hdl/fasta_stream_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_stream_validator_core
// FASTA-like byte stream checker: passes name bytes and upper-cased bases,
// reports record ends and the first format error.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one byte per transfer on s_tdata, s_tuser = 1 marks an
//   end-of-stream transfer (byte ignored). Master channel: zero or one result
//   per input transfer; m_tuser carries the result kind, m_tdata the name
//   byte or base letter (zero for other kinds).
//   A result appears on the master side the cycle after its input transfer.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the single parser state register feeding the result register.
//   After an error the block drops data silently until an end-of-stream
//   transfer, which re-arms it without a result.
//   Reset clears the parser to line start with no open record and empties
//   the result register.
//   When the receiver stalls with a result held, s_tready drops until the
//   result is taken; a held result can be replaced in the same cycle it
//   drains.
// ----------------------------------------------------------------------------
module fasta_stream_validator_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tuser,   // [0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] result_byte
    output logic [2:0] m_tuser    // [2:0] result_kind
);

    fsv_pkg::parse_state_t state_reg;
    fsv_pkg::parse_state_t state_next;
    fsv_pkg::result_t      step_result;
    fsv_pkg::result_t      out_result;
    logic                  step_emit;
    logic                  can_load;
    logic                  accept;

    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    fsv_step u_step
    (
        .state      (state_reg),
        .mode       (s_tuser),
        .symbol     (s_tdata),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fsv_pkg::STATE_RESET;
        else if (accept)
            state_reg <= state_next;
    end

    fsv_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && step_emit),
        .load_data (step_result),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (out_result)
    );

    assign m_tdata = out_result.data;
    assign m_tuser = out_result.kind;

endmodule

FILE: hdl/fsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_checker
// Port-level checks for fasta_stream_validator_core.
// ----------------------------------------------------------------------------
module fsv_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= fsv_pkg::KIND_ERROR)
        else $error("result kind out of range");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != fsv_pkg::KIND_NAME && m_tuser != fsv_pkg::KIND_BASE
        |-> m_tdata == 8'd0)
        else $error("nonzero byte on status result");

    a_base: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == fsv_pkg::KIND_BASE |->
        m_tdata == fsv_pkg::CHAR_A || m_tdata == fsv_pkg::CHAR_C ||
        m_tdata == fsv_pkg::CHAR_G || m_tdata == fsv_pkg::CHAR_N ||
        m_tdata == fsv_pkg::CHAR_T)
        else $error("base result not an upper-case base");

    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && m_tvalid && m_tready
        |=> !m_tvalid || m_tuser == fsv_pkg::KIND_END_REC ||
            m_tuser == fsv_pkg::KIND_END_EMPTY || m_tuser == fsv_pkg::KIND_ERROR)
        else $error("end-of-stream gave a data result");

endmodule

bind fasta_stream_validator_core fsv_checker u_fsv_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
